[sv/shabs_pkg.sv]
// Shared types, round constants and mixing functions of the SHA-256 byte stream hasher.
package shabs_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   localparam int DIGEST_WORDS = 8;
   localparam int SCHED_WORDS  = 16;
   localparam int ROUNDS       = 64;

   localparam word_type H_INIT [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type K_TABLE [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam byte_type PAD_MARK   = 8'h80;
   localparam byte_type PAD_ZERO   = 8'h00;
   localparam logic [5:0] LEN_SLOT = 6'd56;

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type choose(input word_type e, input word_type f, input word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b, input word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

[sv/shabs_if.sv]
// Valid/ready channel interfaces for message bytes and digest words.
interface shabs_req_if import shabs_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     has_byte;
   logic     end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface shabs_rsp_if import shabs_pkg::*;;
   logic       valid;
   logic       ready;
   word_type   digest_word;
   logic [2:0] word_index;
   logic       last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[sv/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte stream hasher: byte packing, padding sequencer and one shared round unit.
//
//  channel  direction  transaction carries
//  req_ch   in         data_byte[7:0], has_byte, end_of_message
//  rsp_ch   out        digest_word[31:0], word_index[2:0], last_word
//
// A transaction with a byte and no close leaves the block idle, except the byte that fills the
// block: that one holds req_ch.ready low while the block is compressed (64 rounds, then the
// chain update). A close pads one byte per cycle up to the length slot (if the 0x80 mark
// lands past byte 55, pad to the block end and compress one extra block first), then
// loads the length and runs the final block before offering eight digest words.
// Reset is synchronous and leaves the block idle; a stalled rsp_ch holds the current word.
module sha256_byte_stream_hasher_top import shabs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   shabs_req_if.sink   req_ch,
   shabs_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   word_type    chain_ff [DIGEST_WORDS];
   word_type    chain_in [DIGEST_WORDS];
   word_type    v_ff [DIGEST_WORDS];         // working variables a..h
   word_type    v_in [DIGEST_WORDS];
   word_type    w_ff [SCHED_WORDS];          // block words, then schedule window
   word_type    w_in [SCHED_WORDS];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        close_ff, close_in;          // message closed, digest still owed
   logic        final_ff, final_in;          // block under compression carries the length
   logic        pad80_ff, pad80_in;          // 0x80 mark not yet written

   logic        wr_en;
   byte_type    wr_byte;
   logic [4:0]  lane_base;
   word_type    t1, t2, w_next;
   logic [63:0] bit_len;

   // handshake: take bytes only when idle, offer words only when emitting
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.digest_word = chain_ff[0];
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.last_word   = (out_idx_ff == 3'd7);

   assign bit_len   = {count_ff, 3'b000};
   assign lane_base = {2'd3 - fill_ff[1:0], 3'b000};

   always_comb begin
      state_in   = state_ff;
      chain_in   = chain_ff;
      v_in       = v_ff;
      w_in       = w_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      rnd_in     = rnd_ff;
      out_idx_in = out_idx_ff;
      close_in   = close_ff;
      final_in   = final_ff;
      pad80_in   = pad80_ff;
      wr_en      = 1'b0;
      wr_byte    = req_ch.data_byte;

      // one round of the compression, shared by every block
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6])
         + K_TABLE[rnd_ff] + w_ff[0];
      t2 = big_sigma0(v_ff[0]) + majority(v_ff[0], v_ff[1], v_ff[2]);
      w_next = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.has_byte) begin
                  wr_en    = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_ch.has_byte && (fill_ff == 6'd63)) begin
                  // block full: compress, then pad if the message closes here
                  state_in = ST_ROUND;
                  v_in     = chain_ff;
                  rnd_in   = '0;
                  final_in = 1'b0;
                  close_in = req_ch.end_of_message;
                  pad80_in = req_ch.end_of_message;
               end else if (req_ch.end_of_message) begin
                  state_in = ST_PAD;
                  close_in = 1'b1;
                  pad80_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[SCHED_WORDS - 1] = w_next;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            if (final_ff) begin
               state_in   = ST_OUT;
               out_idx_in = '0;
            end else if (close_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (!pad80_ff && (fill_ff == LEN_SLOT)) begin
               // length goes into the last two words, then the final block
               w_in[SCHED_WORDS - 2] = bit_len[63:32];
               w_in[SCHED_WORDS - 1] = bit_len[31:0];
               fill_in  = '0;
               state_in = ST_ROUND;
               v_in     = chain_ff;
               rnd_in   = '0;
               final_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_byte  = pad80_ff ? PAD_MARK : PAD_ZERO;
               pad80_in = 1'b0;
               fill_in  = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  // no room for the length: compress and pad a further block
                  state_in = ST_ROUND;
                  v_in     = chain_ff;
                  rnd_in   = '0;
                  final_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                  chain_in[i] = chain_ff[i + 1];
               end
               chain_in[DIGEST_WORDS - 1] = chain_ff[0];
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  // restart for the next message
                  chain_in = H_INIT;
                  fill_in  = '0;
                  count_in = '0;
                  close_in = 1'b0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         w_in[fill_ff[5:2]][lane_base +: 8] = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= H_INIT;
         fill_ff    <= '0;
         count_ff   <= '0;
         rnd_ff     <= '0;
         out_idx_ff <= '0;
         close_ff   <= 1'b0;
         final_ff   <= 1'b0;
         pad80_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         rnd_ff     <= rnd_in;
         out_idx_ff <= out_idx_in;
         close_ff   <= close_in;
         final_ff   <= final_in;
         pad80_ff   <= pad80_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   // never take a byte while a digest word is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while digest pending");

   // a byte that completes the block starts a compression
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.has_byte && (fill_ff == 6'd63))
      |=> (state_ff == ST_ROUND) && (rnd_ff == 6'd0))
      else $error("full block not compressed");

   // sixty-four rounds end in the chain update
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (rnd_ff == 6'd63)) |=> (state_ff == ST_ADD))
      else $error("round count overrun");

   // the last digest word leaves the block clean for the next message
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word)
      |=> (fill_ff == 6'd0) && (count_ff == 61'd0) && (chain_ff[0] == H_INIT[0])
          && (state_ff == ST_IDLE))
      else $error("state not restarted after digest");

endmodule

[dv/sha256_digest_checker.sv]
// Digest checker: models SHA-256 over accepted request transactions and compares digest words.
`timescale 1ns / 100ps

module sha256_digest_checker import shabs_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   shabs_req_if  req_mon,
   shabs_rsp_if  rsp_mon,
   output int    fail_count,
   output int    words_pending,
   output int    messages_closed,
   output int    bytes_absorbed,
   output int    words_checked
);

   typedef struct packed {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_beat_type;

   // Own copy of the round constants and initial hash, kept apart from the design's tables.
   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam byte_type PAD_START   = 8'h80;
   localparam int       LENGTH_SLOT = 56;

   digest_beat_type words_due [$];
   word_type        chain_words [8];
   byte_type        block_bytes [64];
   logic [5:0]      block_fill;
   logic [60:0]     msg_length;

   int fails     = 0;
   int mismatches = 0;
   int closed    = 0;
   int absorbed  = 0;
   int checked   = 0;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over block_bytes and fold the result into chain_words.
   function automatic void absorb_block();
      word_type sched [64];
      word_type v [8];
      word_type s0, s1, t1, t2;
      int i;
      for (i = 0; i < 16; i++) begin
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                     block_bytes[4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      for (i = 0; i < 8; i++) v[i] = chain_words[i];
      for (i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
   endfunction

   function automatic void restart_message();
      int i;
      for (i = 0; i < 8; i++) chain_words[i] = START_HASH[i];
      block_fill = '0;
      msg_length = '0;
   endfunction

   // Pad, append the bit length, finish and queue the eight digest words.
   function automatic void close_message();
      int pos, i;
      logic [63:0] bit_len;
      digest_beat_type beat;
      pos = block_fill;
      block_bytes[pos] = PAD_START;
      pos++;
      if (pos > LENGTH_SLOT) begin
         for (i = pos; i < 64; i++) block_bytes[i] = '0;
         absorb_block();
         pos = 0;
      end
      for (i = pos; i < LENGTH_SLOT; i++) block_bytes[i] = '0;
      bit_len = {msg_length, 3'b000};
      for (i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
      absorb_block();
      for (i = 0; i < 8; i++) begin
         beat.word  = chain_words[i];
         beat.index = i[2:0];
         beat.last  = (i == 7);
         words_due.push_back(beat);
      end
      restart_message();
   endfunction

   always @(posedge clock) begin
      digest_beat_type got, want;
      if (reset) begin
         words_due.delete();
         restart_message();
      end else begin
         // Check results before predicting, so a close at this edge queues behind them.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word};
            checked++;
            if (words_due.size() == 0) begin
               fails++;
               if (mismatches < 10)
                  $display("[%0t] digest word %h idx %0d with nothing outstanding",
                           $realtime, got.word, got.index);
               mismatches++;
            end else begin
               want = words_due.pop_front();
               if (got.word !== want.word || got.index !== want.index ||
                   got.last !== want.last) begin
                  fails++;
                  if (mismatches < 10)
                     $display("[%0t] expected %h idx %0d last %0b, got %h idx %0d last %0b",
                              $realtime, want.word, want.index, want.last,
                              got.word, got.index, got.last);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.has_byte) begin
               block_bytes[block_fill] = req_mon.data_byte;
               block_fill = block_fill + 6'd1;
               msg_length = msg_length + 61'd1;
               absorbed++;
               if (block_fill == 6'd0) absorb_block();
            end
            if (req_mon.end_of_message) begin
               close_message();
               closed++;
            end
         end
      end
      fail_count      <= fails;
      words_pending   <= words_due.size();
      messages_closed <= closed;
      bytes_absorbed  <= absorbed;
      words_checked   <= checked;
   end

endmodule

[dv/sha256_byte_stream_hasher_top_tb.sv]
// Testbench top: clock, reset, message stimulus, digest back-pressure, watchdog and verdict.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_top_tb import shabs_pkg::*;;

   localparam int ITEM_TARGET   = 360;   // stop starting messages past this many transactions
   localparam int QUIET_AFTER   = 300;   // no idling on either side from here on
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
   localparam int SETTLE_CYCLES = 100;  // covers a full block compression plus margin

   // Lengths that put the pad mark and the length field on every block boundary.
   localparam int LEN_EDGES [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   logic clock;
   logic reset;
   bit   gaps_on;
   int   items_sent;
   int   messages_sent;
   int   msg_len;

   int fail_count, words_pending, messages_closed, bytes_absorbed, words_checked;

   shabs_req_if req_ch ();
   shabs_rsp_if rsp_ch ();

   sha256_byte_stream_hasher_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sha256_digest_checker digest_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .words_pending   (words_pending),
      .messages_closed (messages_closed),
      .bytes_absorbed  (bytes_absorbed),
      .words_checked   (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one transaction. Inputs move only on the falling edge; acceptance is
   // judged on the rising edge. An optional idle burst goes in front, so gaps land
   // wherever the block happens to be in its work.
   task automatic send_item(input byte_type value, input logic with_byte, input logic closes);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.data_byte      = value;
      req_ch.has_byte       = with_byte;
      req_ch.end_of_message = closes;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid and hold off until every outstanding digest word has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   // Random content; the close rides on the last byte or comes as a transaction of its
   // own. Now and then slip in a transaction that carries neither byte nor close.
   task automatic send_message(input int len, input bit close_on_last);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, close_on_last && (i == len - 1));
      end
      if (len == 0 || !close_on_last)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      messages_sent++;
   endtask

   // Mostly short messages, with a fair share on the padding boundaries.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return $urandom_range(0, 12);
      if (roll < 9) return LEN_EDGES[$urandom_range(0, 9)];
      return $urandom_range(0, 130);
   endfunction

   // Digest back-pressure: random bursts of stalled cycles while idling is on.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Watchdog: give up after too long with no transaction on either channel.
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("sha256_byte_stream_hasher_top verification failed");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      gaps_on               = 1'b0;
      items_sent            = 0;
      messages_sent         = 0;
      msg_len               = 0;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = '0;
      req_ch.has_byte       = 1'b0;
      req_ch.end_of_message = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message straight after reset.
      send_item(8'hff, 1'b0, 1'b1);
      // A transaction with neither byte nor close must leave no trace.
      send_item(8'h5a, 1'b0, 1'b0);
      // "abc", close taken together with the last byte.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Extreme byte values, then a close with no byte and stray data on the bus.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'ha5, 1'b0, 1'b1);
      // One byte that looks like the pad mark, closed at once.
      send_item(8'h80, 1'b1, 1'b1);
      // Empty message right after a close.
      send_item(8'h00, 1'b0, 1'b1);
      hold_until_drained();

      // Random messages; idling switched per message so calm stretches appear too.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= QUIET_AFTER)
            gaps_on = 1'b0;
         else
            gaps_on = ($urandom_range(0, 3) != 0);
         // Trim the last message so the run lands close to the target.
         msg_len = pick_length();
         if (msg_len > ITEM_TARGET - items_sent)
            msg_len = ITEM_TARGET - items_sent;
         send_message(msg_len, 1'($urandom_range(0, 1)));
         if (messages_sent == 6) hold_until_drained();
      end

      // Drain, then allow the latency of one more block before the verdict.
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d messages, %0d message bytes and %0d transactions;",
               messages_closed, bytes_absorbed, items_sent);
      $display("%0d digest words compared, %0d failures.", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("sha256_byte_stream_hasher_top verification clean");
      end else begin
         $display("sha256_byte_stream_hasher_top verification failed");
      end
      $finish;
   end

endmodule
